### src/hdp_pkg.sv
// ----------------------------------------------------------------------------
// hdp_pkg: HTTP date parser shared types
// Item and result layouts, character codes, field defaults, month decode.
// ----------------------------------------------------------------------------
package hdp_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam int DAY_DEFAULT    = 32;
	localparam int HOUR_DEFAULT   = 24;
	localparam int MINUTE_DEFAULT = 60;
	localparam int SECOND_DEFAULT = 60;
	localparam int YEAR_DEFAULT   = 1969;

	localparam int YEAR_SHORT_MAX = 100;
	localparam int YEAR_PIVOT     = 70;
	localparam int YEAR_BASE_20   = 2000;
	localparam int YEAR_BASE_19   = 1900;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] year;
		logic [3:0]  month;
		logic [15:0] day;
		logic [15:0] hour;
		logic [15:0] minute;
		logic [15:0] second;
	} out_item_t;

	typedef struct packed {
		logic            failed;
		logic [2:0][7:0] letters;
	} res_flags_t;

	function automatic logic [3:0] decode_month(input logic [2:0][7:0] l);
		logic [3:0] m;
		m = 4'd0;
		unique case (l[0])
			"A": m = (l[1] == "p") ? 4'd4 : 4'd8;
			"D": m = 4'd12;
			"F": m = 4'd2;
			"J": begin
				if (l[1] == "a") m = 4'd1;
				else m = (l[2] == "l") ? 4'd7 : 4'd6;
			end
			"M": m = (l[2] == "r") ? 4'd3 : 4'd5;
			"N": m = 4'd11;
			"O": m = 4'd10;
			"S": m = 4'd9;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

endpackage

### src/hdp_if.sv
// ----------------------------------------------------------------------------
// hdp_if: HTTP date parser channels
// Valid/ready channels for characters in and parsed dates out.
// ----------------------------------------------------------------------------
interface hdp_char_if import hdp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hdp_date_if import hdp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/hdp_parse.sv
// ----------------------------------------------------------------------------
// hdp_parse: character phase machine
// Layout detection, month letters, saturating decimal fields; closes the
// pending field at end of string and clears itself after the last character.
// ----------------------------------------------------------------------------
module hdp_parse import hdp_pkg::*; #(
	parameter int NUM_WIDTH = 16,
	localparam int FW = (NUM_WIDTH > 16) ? NUM_WIDTH : 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    ch,
	input  logic          last,
	output res_flags_t    flags,
	output logic [FW-1:0] day,
	output logic [FW-1:0] hour,
	output logic [FW-1:0] minute,
	output logic [FW-1:0] second,
	output logic [FW-1:0] year
);

	typedef enum logic [2:0] {
		PH_START, PH_END, PH_MON, PH_DAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC
	} phase_t;

	localparam int SW = NUM_WIDTH + 4;

	phase_t                phase_q, ph;
	logic [NUM_WIDTH-1:0]  acc_q, acc, acc_sat;
	logic [SW-1:0]         acc_sum;
	logic [2:0][7:0]       let_q, let_v;
	logic [1:0]            cnt_q, cnt;
	logic                  skip_q, skip, asc_q, asc, fail_q, fail;
	logic [FW-1:0]         day_q, hour_q, min_q, sec_q, year_q;
	logic [FW-1:0]         dy, hr, mi, se, yr;
	logic                  is_dig, is_let, st1, fin;

	assign is_dig = (ch >= "0") && (ch <= "9");
	assign is_let = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));

	// acc * 10 + digit, clamp at all ones
	assign acc_sum = SW'({acc_q, 3'b000}) + SW'({acc_q, 1'b0}) + SW'(ch[3:0]);
	assign acc_sat = (|acc_sum[SW-1:NUM_WIDTH]) ? '1 : acc_sum[NUM_WIDTH-1:0];

	always_comb begin
		ph   = phase_q;
		acc  = acc_q;
		let_v = let_q;
		cnt  = cnt_q;
		skip = skip_q;
		asc  = asc_q;
		fail = fail_q;
		st1  = 1'b0;
		if (!fail_q && phase_q != PH_END) begin
			if (ch == CH_NUL) begin
				st1 = 1'b1;
				ph  = PH_END;
			end else begin
				unique case (phase_q)
					PH_START: begin
						if (ch == CH_SPACE) begin
							ph  = PH_MON;
							asc = 1'b1;
						end else if (ch == CH_COMMA) begin
							ph = PH_DAY;
						end
					end
					PH_MON: begin
						if (is_let) begin
							if (cnt_q != 2'd3) begin
								cnt = cnt_q + 2'd1;
								unique case (cnt_q)
									2'd0: let_v[0] = ch;
									2'd1: let_v[1] = ch;
									2'd2: let_v[2] = ch;
									default: ;
								endcase
							end
						end else if (cnt_q != 2'd3) begin
							fail = 1'b1;
						end else begin
							cnt = 2'd0;
							acc = '0;
							ph  = asc_q ? PH_DAY : PH_YEAR;
						end
					end
					PH_DAY: begin
						if (ch == CH_SPACE && skip_q) begin
						end else if (is_dig) begin
							skip = 1'b0;
							acc  = acc_sat;
						end else begin
							st1 = 1'b1;
							acc = '0;
							ph  = asc_q ? PH_HOUR : PH_MON;
						end
					end
					PH_YEAR: begin
						if (is_dig) acc = acc_sat;
						else begin
							st1 = 1'b1;
							acc = '0;
							ph  = asc_q ? PH_END : PH_HOUR;
						end
					end
					PH_HOUR: begin
						if (is_dig) acc = acc_sat;
						else begin
							st1 = 1'b1;
							acc = '0;
							ph  = PH_MIN;
						end
					end
					PH_MIN: begin
						if (is_dig) acc = acc_sat;
						else begin
							st1 = 1'b1;
							acc = '0;
							ph  = PH_SEC;
						end
					end
					PH_SEC: begin
						if (is_dig) acc = acc_sat;
						else begin
							st1 = 1'b1;
							acc = '0;
							ph  = asc_q ? PH_YEAR : PH_END;
						end
					end
					PH_END: ;
				endcase
			end
		end

		dy = day_q;
		hr = hour_q;
		mi = min_q;
		se = sec_q;
		yr = year_q;
		// close the field left by this character
		if (st1) begin
			unique case (phase_q)
				PH_DAY:  dy = FW'(acc_q);
				PH_YEAR: yr = FW'(acc_q);
				PH_HOUR: hr = FW'(acc_q);
				PH_MIN:  mi = FW'(acc_q);
				PH_SEC:  se = FW'(acc_q);
				default: ;
			endcase
		end
		// store a number still pending at end of string
		fin = last && !fail && ph != PH_END;
		if (fin) begin
			unique case (ph)
				PH_DAY:  dy = FW'(acc);
				PH_YEAR: yr = FW'(acc);
				PH_HOUR: hr = FW'(acc);
				PH_MIN:  mi = FW'(acc);
				PH_SEC:  se = FW'(acc);
				default: ;
			endcase
		end
	end

	assign flags.failed  = fail;
	assign flags.letters = let_v;
	assign day    = dy;
	assign hour   = hr;
	assign minute = mi;
	assign second = se;
	assign year   = yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			let_q   <= '0;
			cnt_q   <= 2'd0;
			skip_q  <= 1'b1;
			asc_q   <= 1'b0;
			fail_q  <= 1'b0;
			day_q   <= FW'(DAY_DEFAULT);
			hour_q  <= FW'(HOUR_DEFAULT);
			min_q   <= FW'(MINUTE_DEFAULT);
			sec_q   <= FW'(SECOND_DEFAULT);
			year_q  <= FW'(YEAR_DEFAULT);
		end else if (step) begin
			if (last) begin
				phase_q <= PH_START;
				acc_q   <= '0;
				let_q   <= '0;
				cnt_q   <= 2'd0;
				skip_q  <= 1'b1;
				asc_q   <= 1'b0;
				fail_q  <= 1'b0;
				day_q   <= FW'(DAY_DEFAULT);
				hour_q  <= FW'(HOUR_DEFAULT);
				min_q   <= FW'(MINUTE_DEFAULT);
				sec_q   <= FW'(SECOND_DEFAULT);
				year_q  <= FW'(YEAR_DEFAULT);
			end else begin
				phase_q <= ph;
				acc_q   <= acc;
				let_q   <= let_v;
				cnt_q   <= cnt;
				skip_q  <= skip;
				asc_q   <= asc;
				fail_q  <= fail;
				day_q   <= dy;
				hour_q  <= hr;
				min_q   <= mi;
				sec_q   <= se;
				year_q  <= yr;
			end
		end
	end

endmodule

### src/hdp_result.sv
// ----------------------------------------------------------------------------
// hdp_result: date result register
// Month decode, widening of years up to 100, ok gating and the output register.
// ----------------------------------------------------------------------------
module hdp_result import hdp_pkg::*; #(
	parameter int NUM_WIDTH = 16,
	localparam int FW = (NUM_WIDTH > 16) ? NUM_WIDTH : 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  res_flags_t    flags,
	input  logic [FW-1:0] day,
	input  logic [FW-1:0] hour,
	input  logic [FW-1:0] minute,
	input  logic [FW-1:0] second,
	input  logic [FW-1:0] year,
	input  logic          ready,
	output logic          valid,
	output out_item_t     data
);

	logic [3:0]    month;
	logic          ok;
	logic [FW-1:0] year_w;
	out_item_t     res;
	logic          vld_q;
	out_item_t     data_q;

	assign month = decode_month(flags.letters);
	assign ok    = !flags.failed && month != 4'd0;

	always_comb begin
		year_w = year;
		if (year <= FW'(YEAR_SHORT_MAX)) begin
			year_w = year + ((year < FW'(YEAR_PIVOT)) ? FW'(YEAR_BASE_20) : FW'(YEAR_BASE_19));
		end
	end

	always_comb begin
		res = '0;
		if (ok) begin
			res.ok     = 1'b1;
			res.year   = year_w[15:0];
			res.month  = month;
			res.day    = day[15:0];
			res.hour   = hour[15:0];
			res.minute = minute[15:0];
			res.second = second[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign valid = vld_q;
	assign data  = data_q;

endmodule

### src/http_date_parser_top.sv
// ----------------------------------------------------------------------------
// http_date_parser_top: streaming HTTP date parser
// Parses RFC 1123, RFC 850 and asctime date strings into date fields.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one ASCII character per request, with last set on the
//   final character of a string. dates carries one parsed result per string:
//   ok, year, month, day, hour, minute and second; all zero when ok is low.
//   A character is registered in the input register at acceptance and is then
//   processed by the phase machine; when the last character of a string is
//   processed, the result is loaded into the output register and offered on
//   dates. Throughput is one character per cycle while no last character
//   waits for the output register, with one phase machine update per character.
//   A stalled dates channel holds the result; characters that yield no
//   result keep flowing, and the next last character waits in the input
//   register until the output register is free.
//   Reset clears the valid bits of both channel registers and returns the
//   parser to the start of a string with all fields at their defaults.
// ----------------------------------------------------------------------------
module http_date_parser_top import hdp_pkg::*; #(
	parameter int NUM_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	hdp_char_if.sink   chars,
	hdp_date_if.source dates
);

	localparam int FW = (NUM_WIDTH > 16) ? NUM_WIDTH : 16;

	logic          vld_s1;
	logic [7:0]    ch_s1;
	logic          last_s1;
	logic          res_free, consume, load;
	res_flags_t    flags;
	logic [FW-1:0] day, hour, minute, second, year;

	assign res_free    = !dates.valid || dates.ready;
	assign consume     = vld_s1 && (!last_s1 || res_free);
	assign load        = consume && last_s1;
	assign chars.ready = !vld_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (chars.ready) begin
			vld_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.data.ch;
			last_s1 <= chars.data.last;
		end
	end

	hdp_parse #(.NUM_WIDTH(NUM_WIDTH)) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.ch     (ch_s1),
		.last   (last_s1),
		.flags  (flags),
		.day    (day),
		.hour   (hour),
		.minute (minute),
		.second (second),
		.year   (year)
	);

	hdp_result #(.NUM_WIDTH(NUM_WIDTH)) u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.flags  (flags),
		.day    (day),
		.hour   (hour),
		.minute (minute),
		.second (second),
		.year   (year),
		.ready  (dates.ready),
		.valid  (dates.valid),
		.data   (dates.data)
	);

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> res_free) else $error("result loaded over a pending result");
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> dates.valid) else $error("last character gave no result");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dates.valid && !dates.data.ok) |->
		(dates.data.year == 16'd0 && dates.data.month == 4'd0 && dates.data.day == 16'd0))
		else $error("failed result carries nonzero fields");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(dates.valid && dates.data.ok) |->
		(dates.data.month >= 4'd1 && dates.data.month <= 4'd12))
		else $error("month out of range on valid date");
`endif

endmodule

### tb/sv/tb_http_date_parser_top.sv
// ----------------------------------------------------------------------------
// tb_http_date_parser_top: HTTP date parser testbench
// Streams directed and random date strings through the parser, with random
// stalls on both channels, and checks every parsed date field by field.
// ----------------------------------------------------------------------------
module tb_http_date_parser_top;
	import hdp_pkg::*;

	typedef logic [7:0] text_t[$];

	typedef enum logic [2:0] {
		SCAN_LEAD, SCAN_DONE, SCAN_MONTH, SCAN_DAY,
		SCAN_YEAR, SCAN_HOUR, SCAN_MINUTE, SCAN_SECOND
	} scan_phase_t;

	typedef struct {
		string      text;
		bit         typed;
		out_item_t  want;
		int         patch_at;
		logic [7:0] patch_ch;
	} probe_t;

	localparam int        NUM_W        = 16;
	localparam longint    NUM_CAP      = (64'd1 << NUM_W) - 1;
	localparam int        RANDOM_CHARS = 1360;
	localparam int        CALM_AFTER   = 1150;
	localparam out_item_t NO_DATE      = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hdp_char_if chars ();
	hdp_date_if dates ();

	http_date_parser_top #(.NUM_WIDTH(NUM_W)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.dates  (dates)
	);

	string mon_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
		"Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
	string day_short[7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
	string day_long[7] = '{"Monday", "Tuesday", "Wednesday", "Thursday",
		"Friday", "Saturday", "Sunday"};

	scan_phase_t scan_phase;
	longint      num_acc;
	logic [7:0]  mon_chars[3];
	int          mon_count;
	bit          lead_blank;
	bit          asc_form;
	bit          bad_date;
	longint      day_v;
	longint      hour_v;
	longint      minute_v;
	longint      second_v;
	longint      year_v;

	out_item_t dates_due[$];
	out_item_t head;
	probe_t    probes[$];
	int        errors = 0;
	int        random_sent = 0;
	bit        calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_scan();
		scan_phase = SCAN_LEAD;
		num_acc    = 0;
		mon_chars  = '{default: 8'h00};
		mon_count  = 0;
		lead_blank = 1'b1;
		asc_form   = 1'b0;
		bad_date   = 1'b0;
		day_v      = DAY_DEFAULT;
		hour_v     = HOUR_DEFAULT;
		minute_v   = MINUTE_DEFAULT;
		second_v   = SECOND_DEFAULT;
		year_v     = YEAR_DEFAULT;
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void add_digit(logic [7:0] c);
		num_acc = num_acc * 10 + (longint'(c) - longint'("0"));
		if (num_acc > NUM_CAP) num_acc = NUM_CAP;
	endfunction

	function automatic void bank_number();
		case (scan_phase)
			SCAN_DAY: day_v = num_acc;
			SCAN_YEAR: year_v = num_acc;
			SCAN_HOUR: hour_v = num_acc;
			SCAN_MINUTE: minute_v = num_acc;
			SCAN_SECOND: second_v = num_acc;
			default: ;
		endcase
	endfunction

	function automatic void next_field(scan_phase_t nxt);
		bank_number();
		num_acc = 0;
		scan_phase = nxt;
	endfunction

	function automatic void scan_char(logic [7:0] c);
		case (scan_phase)
			SCAN_LEAD: begin
				if (c == CH_SPACE) begin
					scan_phase = SCAN_MONTH;
					asc_form = 1'b1;
				end else if (c == CH_COMMA) begin
					scan_phase = SCAN_DAY;
				end
			end
			SCAN_MONTH: begin
				if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
					if (mon_count < 3) begin
						mon_chars[mon_count] = c;
						mon_count++;
					end
				end else if (mon_count < 3) begin
					bad_date = 1'b1;
				end else begin
					mon_count = 0;
					num_acc = 0;
					scan_phase = asc_form ? SCAN_DAY : SCAN_YEAR;
				end
			end
			SCAN_DAY: begin
				if (is_num(c)) begin
					lead_blank = 1'b0;
					add_digit(c);
				end else if (c != CH_SPACE || !lead_blank) begin
					next_field(asc_form ? SCAN_HOUR : SCAN_MONTH);
				end
			end
			SCAN_YEAR: begin
				if (is_num(c)) add_digit(c);
				else next_field(asc_form ? SCAN_DONE : SCAN_HOUR);
			end
			SCAN_HOUR: begin
				if (is_num(c)) add_digit(c);
				else next_field(SCAN_MINUTE);
			end
			SCAN_MINUTE: begin
				if (is_num(c)) add_digit(c);
				else next_field(SCAN_SECOND);
			end
			SCAN_SECOND: begin
				if (is_num(c)) add_digit(c);
				else next_field(asc_form ? SCAN_YEAR : SCAN_DONE);
			end
			default: ;
		endcase
	endfunction

	function automatic bit date_step(logic [7:0] c, logic fin, output out_item_t res);
		logic [3:0] mon;
		longint     yr;
		res = NO_DATE;
		if (!bad_date && scan_phase != SCAN_DONE) begin
			if (c == CH_NUL) begin
				bank_number();
				scan_phase = SCAN_DONE;
			end else begin
				scan_char(c);
			end
		end
		if (!fin) return 1'b0;
		if (!bad_date && scan_phase != SCAN_DONE) begin
			bank_number();
			scan_phase = SCAN_DONE;
		end
		case (mon_chars[0])
			"A": mon = (mon_chars[1] == "p") ? 4'd4 : 4'd8;
			"D": mon = 4'd12;
			"F": mon = 4'd2;
			"J": mon = (mon_chars[1] == "a") ? 4'd1 : (mon_chars[2] == "l") ? 4'd7 : 4'd6;
			"M": mon = (mon_chars[2] == "r") ? 4'd3 : 4'd5;
			"N": mon = 4'd11;
			"O": mon = 4'd10;
			"S": mon = 4'd9;
			default: mon = 4'd0;
		endcase
		yr = year_v;
		if (yr <= YEAR_SHORT_MAX) yr += (yr < YEAR_PIVOT) ? YEAR_BASE_20 : YEAR_BASE_19;
		if (!bad_date && mon != 4'd0) begin
			res.ok     = 1'b1;
			res.year   = yr[15:0];
			res.month  = mon;
			res.day    = day_v[15:0];
			res.hour   = hour_v[15:0];
			res.minute = minute_v[15:0];
			res.second = second_v[15:0];
		end
		clear_scan();
		return 1'b1;
	endfunction

	function automatic out_item_t date_of(int y, int m, int d, int h, int mi, int s);
		out_item_t res;
		res.ok     = 1'b1;
		res.year   = y[15:0];
		res.month  = m[3:0];
		res.day    = d[15:0];
		res.hour   = h[15:0];
		res.minute = mi[15:0];
		res.second = s[15:0];
		return res;
	endfunction

	function automatic void add_probe(string text, bit typed = 1'b0,
			out_item_t want = '0, int patch_at = -1, logic [7:0] patch_ch = 8'h00);
		probe_t p;
		p.text     = text;
		p.typed    = typed;
		p.want     = want;
		p.patch_at = patch_at;
		p.patch_ch = patch_ch;
		probes.push_back(p);
	endfunction

	function automatic text_t to_text(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
		return t;
	endfunction

	function automatic string pick_month();
		string s;
		s = mon_names[$urandom_range(0, 11)];
		case ($urandom_range(0, 15))
			13: s[0] = s[0] + 8'd32;
			14: s = s.substr(0, 1);
			15: begin
				for (int i = 0; i < 3; i++)
					s[i] = $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
						: 8'($urandom_range("a", "z"));
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic string pick_num(int lo, int hi, bit pad_blank);
		if ($urandom_range(0, 19) == 0) return $sformatf("%0d", $urandom_range(0, 9999999));
		if (pad_blank) return $sformatf("%2d", $urandom_range(lo, hi));
		return $sformatf("%02d", $urandom_range(lo, hi));
	endfunction

	function automatic text_t dated_text();
		string s;
		text_t t;
		int    cut;
		case ($urandom_range(0, 2))
			0: s = $sformatf("%s, %s %s %s %s:%s:%s GMT", day_short[$urandom_range(0, 6)],
				pick_num(1, 31, 0), pick_month(), pick_num(1900, 2099, 0),
				pick_num(0, 23, 0), pick_num(0, 59, 0), pick_num(0, 59, 0));
			1: s = $sformatf("%s, %s-%s-%s %s:%s:%s GMT", day_long[$urandom_range(0, 6)],
				pick_num(1, 31, 0), pick_month(), pick_num(0, 99, 0),
				pick_num(0, 23, 0), pick_num(0, 59, 0), pick_num(0, 59, 0));
			default: s = $sformatf("%s %s %s %s:%s:%s %s", day_short[$urandom_range(0, 6)],
				pick_month(), pick_num(1, 31, 1), pick_num(0, 23, 0),
				pick_num(0, 59, 0), pick_num(0, 59, 0), pick_num(1900, 2099, 0));
		endcase
		t = to_text(s);
		case ($urandom_range(0, 9))
			0, 1: begin
				cut = $urandom_range(1, t.size());
				while (t.size() > cut) void'(t.pop_back());
			end
			2: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
			default: ;
		endcase
		return t;
	endfunction

	function automatic text_t noise_text();
		string pool;
		text_t t;
		int    n;
		pool = " ,:-0123456789AJaunlpr";
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++)
			t.push_back($urandom_range(0, 1) ? pool[$urandom_range(0, pool.len() - 1)]
				: 8'($urandom_range(0, 255)));
		return t;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic send_char(logic [7:0] c, logic fin, bit typed, out_item_t want);
		out_item_t res;
		if (!calm && $urandom_range(0, 7) == 0) begin
			chars.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		chars.valid     <= 1'b1;
		chars.data.ch   <= c;
		chars.data.last <= fin;
		do @(posedge clk); while (chars.ready !== 1'b1);
		if (date_step(c, fin, res)) dates_due.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	task automatic send_text(text_t t, bit typed, out_item_t want);
		for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1, typed, want);
	endtask

	initial begin
		text_t t;
		chars.valid = 1'b0;
		chars.data = '0;
		clear_scan();

		add_probe("Sun, 06 Nov 1994 08:49:37 GMT", 1, date_of(1994, 11, 6, 8, 49, 37));
		add_probe("Sunday, 06-Nov-94 08:49:37 GMT", 1, date_of(1994, 11, 6, 8, 49, 37));
		add_probe("Sun Nov  6 08:49:37 1994", 1, date_of(1994, 11, 6, 8, 49, 37));
		add_probe("x", 1, NO_DATE);
		add_probe(", 1 No 99", 1, NO_DATE);
		add_probe(", 1 Xyz 99", 1, NO_DATE);
		add_probe(" nov 1", 1, NO_DATE);
		add_probe(", 99999999 Jan 99999999 99999999:99999999:99999999", 1,
			date_of(65535, 1, 65535, 65535, 65535, 65535));
		add_probe(", 1 Feb 69", 1, date_of(2069, 2, 1, 24, 60, 60));
		add_probe(", 1 Feb 70", 1, date_of(1970, 2, 1, 24, 60, 60));
		add_probe(", 31 Feb 100", 1, date_of(2000, 2, 31, 24, 60, 60));
		add_probe(", 0 Feb 101", 1, date_of(101, 2, 0, 24, 60, 60));
		add_probe(", 1 Ma?", 1, NO_DATE, 6, 8'hFF);
		add_probe("?x", 1, NO_DATE, 0, CH_NUL);
		add_probe("?", 1, NO_DATE, 0, CH_NUL);
		add_probe(", 1 A@", 1, NO_DATE);
		add_probe(", 1 Ju");
		add_probe(" Jul");
		add_probe(", 12 Mar 2001 1?:5:6", 0, NO_DATE, 15, CH_NUL);
		add_probe(" Apr 9 1:2:3 05");
		add_probe(", 5 Aug 1999 23:59:60");
		add_probe("Sat, 1 Dec 2000 00:00:00 GMT");
		add_probe("Thursday, 15-Oct-09 12:00:00 GMT");
		add_probe(" Sep 30 7:8:9 1999");
		add_probe(", 2-May-50");
		add_probe(", 4-Jun-88 1:2");

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (probes[k]) begin
			t = to_text(probes[k].text);
			if (probes[k].patch_at >= 0) t[probes[k].patch_at] = probes[k].patch_ch;
			send_text(t, probes[k].typed, probes[k].want);
		end

		while (random_sent < RANDOM_CHARS) begin
			if ($urandom_range(0, 5) == 0) t = noise_text();
			else t = dated_text();
			send_text(t, 1'b0, NO_DATE);
			random_sent += t.size();
			calm = random_sent > CALM_AFTER;
		end
		chars.valid <= 1'b0;

		while (dates_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		dates.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				dates.ready <= 1'b0;
				repeat ($urandom_range(1, 13) - 1) @(negedge clk);
			end else begin
				dates.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dates.valid === 1'b1 && dates.ready === 1'b1) begin
			if (dates_due.size() == 0) begin
				$error("unexpected date: no string pending");
				errors++;
			end else begin
				head = dates_due.pop_front();
				check_field("ok", 32'(head.ok), 32'(dates.data.ok));
				check_field("year", 32'(head.year), 32'(dates.data.year));
				check_field("month", 32'(head.month), 32'(dates.data.month));
				check_field("day", 32'(head.day), 32'(dates.data.day));
				check_field("hour", 32'(head.hour), 32'(dates.data.hour));
				check_field("minute", 32'(head.minute), 32'(dates.data.minute));
				check_field("second", 32'(head.second), 32'(dates.data.second));
			end
		end
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
